[design/matrix_keypad_scanner_macros.svh]
// Assertion helpers for the keypad scanner.
`ifndef MATRIX_KEYPAD_SCANNER_MACROS_SVH
`define MATRIX_KEYPAD_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
`define MKP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("matrix_keypad_scanner: assertion failed");
`define MKP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("matrix_keypad_scanner: assertion failed");
`else
`define MKP_ASSERT_IMP(lbl, ante, cons)
`define MKP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/mkp_pkg.sv]
`default_nettype none

package mkp_pkg;

  localparam int ROWS         = 4;
  localparam int COLS         = 4;
  localparam int HISTORY_BITS = 4;
  localparam int TIME_WIDTH   = 16;

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int KEY_W  = 4;
  localparam int CODE_W = 8;
  localparam int MS_W   = 8;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
  localparam logic [CFG_W-1:0] THR_RESET  = 16'd1000;
  localparam logic [CFG_W-1:0] INTV_RESET = 16'd200;

  localparam logic [IDX_W-1:0] REG_HOLD_THRESHOLD  = 2'd0;
  localparam logic [IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_REPEAT  = 2'd3
  } event_e;

  function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                    input logic [TIME_WIDTH-1:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
  endfunction

  function automatic logic [CODE_W-1:0] key_code(input logic [KEY_W-1:0] key);
    logic [CODE_W-1:0] c;
    unique case (key)
      4'd0:    c = 8'h31;
      4'd1:    c = 8'h32;
      4'd2:    c = 8'h33;
      4'd3:    c = 8'h26;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h25;
      4'd8:    c = 8'h37;
      4'd9:    c = 8'h38;
      4'd10:   c = 8'h39;
      4'd11:   c = 8'h28;
      4'd12:   c = 8'h30;
      4'd13:   c = 8'h1B;
      4'd14:   c = 8'h0D;
      default: c = 8'h27;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/mkp_if.sv]
`default_nettype none

interface mkp_in_if;
  logic                     valid;
  logic                     ready;
  logic [3:0]               column_levels;
  logic [mkp_pkg::MS_W-1:0] elapsed_ms;

  modport source (output valid, column_levels, elapsed_ms, input ready);
  modport sink   (input valid, column_levels, elapsed_ms, output ready);
endinterface

interface mkp_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 drive_row;
  logic [1:0]                 event_kind;
  logic [mkp_pkg::KEY_W-1:0]  key_index;
  logic [mkp_pkg::CODE_W-1:0] key_code;
  logic                       last;

  modport source (output valid, drive_row, event_kind, key_index, key_code, last,
                  input ready);
  modport sink   (input valid, drive_row, event_kind, key_index, key_code, last,
                  output ready);
endinterface

interface mkp_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mkp_pkg::IDX_W-1:0] index;
  logic [mkp_pkg::CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/mkp_lane.sv]
`default_nettype none

// One column of the keypad: keeps debounce and repeat state for every row.
module mkp_lane (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic [mkp_pkg::ROW_W-1:0]         row_i,
  input  wire logic                              level_i,
  input  wire logic [mkp_pkg::MS_W-1:0]          elapsed_i,
  input  wire logic [mkp_pkg::CFG_W-1:0]         thr_i,
  input  wire logic [mkp_pkg::CFG_W-1:0]         intv_i,
  output mkp_pkg::event_e                        kind_o
);

  logic [mkp_pkg::HISTORY_BITS-1:0] hist_q [mkp_pkg::ROWS];
  logic                             rel_q  [mkp_pkg::ROWS];
  logic [mkp_pkg::TIME_WIDTH-1:0]   hold_q [mkp_pkg::ROWS];
  logic [mkp_pkg::TIME_WIDTH-1:0]   lim_q  [mkp_pkg::ROWS];

  logic [mkp_pkg::HISTORY_BITS-1:0] hist_d;
  logic                             rel_d;
  logic [mkp_pkg::TIME_WIDTH-1:0]   hold_d;
  logic [mkp_pkg::TIME_WIDTH-1:0]   lim_d;
  logic [mkp_pkg::TIME_WIDTH-1:0]   thr_t;
  logic [mkp_pkg::TIME_WIDTH-1:0]   intv_t;
  mkp_pkg::event_e                  kind;

  assign thr_t  = mkp_pkg::TIME_WIDTH'(thr_i);
  assign intv_t = mkp_pkg::TIME_WIDTH'(intv_i);

  always_comb begin
    hist_d = {hist_q[row_i][mkp_pkg::HISTORY_BITS-2:0], level_i};
    rel_d  = rel_q[row_i];
    hold_d = hold_q[row_i];
    lim_d  = lim_q[row_i];
    kind   = mkp_pkg::EV_NONE;

    if (&hist_d) begin
      if (!rel_q[row_i]) begin
        kind   = mkp_pkg::EV_RELEASE;
        hold_d = '0;
      end
      rel_d = 1'b1;
    end else if (~|hist_d) begin
      if (rel_q[row_i]) begin
        kind   = mkp_pkg::EV_PRESS;
        hold_d = '0;
      end else begin
        // hold time counts in quarter-ms units of elapsed * 4
        hold_d = mkp_pkg::sat_add(hold_q[row_i],
                                  mkp_pkg::TIME_WIDTH'({elapsed_i, 2'b00}));
      end
      rel_d = 1'b0;
    end

    if (thr_t != '0) begin
      if (hold_d >= thr_t) begin
        if (hold_d >= lim_q[row_i]) begin
          lim_d = mkp_pkg::sat_add(lim_q[row_i], intv_t);
          if (kind == mkp_pkg::EV_NONE) begin
            kind = mkp_pkg::EV_REPEAT;
          end
        end
      end else begin
        lim_d = thr_t;
      end
    end
  end

  assign kind_o = kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < mkp_pkg::ROWS; r++) begin
        hist_q[r] <= '1;
        rel_q[r]  <= 1'b1;
        hold_q[r] <= '0;
        lim_q[r]  <= mkp_pkg::TIME_WIDTH'(mkp_pkg::THR_RESET);
      end
    end else if (en_i) begin
      hist_q[row_i] <= hist_d;
      rel_q[row_i]  <= rel_d;
      hold_q[row_i] <= hold_d;
      lim_q[row_i]  <= lim_d;
    end
  end

endmodule

`default_nettype wire

[design/mkp_merge.sv]
`default_nettype none

// Collects the lane events of one tick and emits them lowest column first.
module mkp_merge (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  mkp_pkg::event_e                kinds_i [mkp_pkg::COLS],
  input  wire logic [mkp_pkg::ROW_W-1:0] row_i,
  input  wire logic [mkp_pkg::ROW_W-1:0] next_row_i,
  output logic                           free_o,
  mkp_out_if.source                      out_o
);

  logic                          busy_q;
  logic [mkp_pkg::COLS-1:0]      pend_q, pend_d;
  mkp_pkg::event_e               kind_q [mkp_pkg::COLS];
  logic [mkp_pkg::ROW_W-1:0]     row_q;
  logic [mkp_pkg::ROW_W-1:0]     drow_q;

  logic [mkp_pkg::COL_W-1:0]     sel;
  logic                          any;
  logic                          is_last;
  logic                          fire;
  logic [mkp_pkg::KEY_W-1:0]     key;

  always_comb begin
    sel = '0;
    for (int c = mkp_pkg::COLS - 1; c >= 0; c--) begin
      if (pend_q[c]) begin
        sel = mkp_pkg::COL_W'(c);
      end
    end
  end

  assign any     = |pend_q;
  // at most one event left
  assign is_last = ((pend_q & (pend_q - mkp_pkg::COLS'(1))) == '0);
  assign fire    = busy_q && out_o.ready;
  assign free_o  = !busy_q || (fire && is_last);
  assign key     = mkp_pkg::KEY_W'({row_q, sel});

  assign out_o.valid      = busy_q;
  assign out_o.drive_row  = 2'(drow_q);
  assign out_o.event_kind = any ? kind_q[sel] : mkp_pkg::EV_NONE;
  assign out_o.key_index  = any ? key : '0;
  assign out_o.key_code   = any ? mkp_pkg::key_code(key) : '0;
  assign out_o.last       = is_last;

  always_comb begin
    for (int c = 0; c < mkp_pkg::COLS; c++) begin
      pend_d[c] = (kinds_i[c] != mkp_pkg::EV_NONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      pend_q <= pend_d;
    end else if (fire) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end
      pend_q <= pend_q & (pend_q - mkp_pkg::COLS'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= kinds_i;
      row_q  <= row_i;
      drow_q <= next_row_i;
    end
  end

endmodule

`default_nettype wire

[design/matrix_keypad_scanner.sv]
// 4x4 keypad scanner with debounce and auto-repeat. Each input word is one
// scan tick: the column levels of the row that was driven and the ms since
// the last tick. Four column lanes update their keys of that row in the
// cycle the word is taken; the tick then yields one to four result words
// (one per event in column order, or a single word with no event), the last
// one flagged. Result words leave one at a time by the single result port,
// which the receiver can stall; the next tick is taken in the same cycle as
// the previous tick's last word leaves. drive_row gives the row to drive for
// the next tick. Configuration writes are always taken.
`default_nettype none

`include "matrix_keypad_scanner_macros.svh"

module matrix_keypad_scanner (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mkp_in_if.sink     in_i,
  mkp_cfg_if.sink    cfg_i,
  mkp_out_if.source  out_o
);

  logic [mkp_pkg::CFG_W-1:0] thr_q;
  logic [mkp_pkg::CFG_W-1:0] intv_q;
  logic [mkp_pkg::ROW_W-1:0] scan_row_q;
  logic [mkp_pkg::ROW_W-1:0] next_row;
  logic                      in_fire;
  logic                      free;
  mkp_pkg::event_e           kinds [mkp_pkg::COLS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= mkp_pkg::THR_RESET;
      intv_q <= mkp_pkg::INTV_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == mkp_pkg::REG_HOLD_THRESHOLD) begin
        thr_q <= cfg_i.data;
      end else if (cfg_i.index == mkp_pkg::REG_REPEAT_INTERVAL) begin
        intv_q <= cfg_i.data;
      end
    end
  end

  assign in_i.ready = free;
  assign in_fire    = in_i.valid && free;
  assign next_row   = (scan_row_q == mkp_pkg::ROW_W'(mkp_pkg::ROWS - 1)) ? '0
                    : scan_row_q + mkp_pkg::ROW_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= '0;
    end else if (in_fire) begin
      scan_row_q <= next_row;
    end
  end

  for (genvar c = 0; c < mkp_pkg::COLS; c++) begin : g_lane
    mkp_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (in_fire),
      .row_i     (scan_row_q),
      .level_i   (in_i.column_levels[c]),
      .elapsed_i (in_i.elapsed_ms),
      .thr_i     (thr_q),
      .intv_i    (intv_q),
      .kind_o    (kinds[c])
    );
  end

  mkp_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_fire),
    .kinds_i    (kinds),
    .row_i      (scan_row_q),
    .next_row_i (next_row),
    .free_o     (free),
    .out_o      (out_o)
  );

  `MKP_ASSERT_NEXT(a_tick_gives_word, in_fire, out_o.valid)
  `MKP_ASSERT_IMP(a_none_is_last, out_o.valid && out_o.event_kind == mkp_pkg::EV_NONE, out_o.last)
  `MKP_ASSERT_IMP(a_hold_while_pending, out_o.valid && !(out_o.ready && out_o.last), !in_i.ready)
  `MKP_ASSERT_NEXT(a_row_advances, in_fire, out_o.drive_row == 2'(scan_row_q))

endmodule

`default_nettype wire

[tb/matrix_keypad_scanner_tb.sv]
`default_nettype none

module matrix_keypad_scanner_tb;
  import mkp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_CYCLES = 300;
  // key codes, key 0 in the low byte
  localparam logic [127:0] KEYPAD_CODES = {
    8'h27, 8'h0D, 8'h1B, 8'h30, 8'h28, 8'h39, 8'h38, 8'h37,
    8'h25, 8'h36, 8'h35, 8'h34, 8'h26, 8'h33, 8'h32, 8'h31
  };

  typedef struct packed {
    logic [1:0]        drive_row;
    event_e            kind;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
    logic              last;
  } scan_word_t;

  typedef struct {
    int         tick_no;
    scan_word_t word;
  } typed_word_t;

  typedef struct packed {
    logic [3:0]      levels;
    logic [MS_W-1:0] ms;
    logic            typed;
    logic [1:0]      next_row;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mkp_in_if  in_if ();
  mkp_cfg_if cfg_if ();
  mkp_out_if out_if ();

  matrix_keypad_scanner DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // keypad model state
  logic [1:0]            scan_row_q;
  logic [3:0]            key_history   [16];
  logic                  key_released  [16];
  logic [TIME_WIDTH-1:0] key_hold_ms   [16];
  logic [TIME_WIDTH-1:0] key_repeat_at [16];
  logic [CFG_W-1:0]      hold_threshold_q;
  logic [CFG_W-1:0]      repeat_interval_q;

  scan_word_t  tick_words [$];
  scan_word_t  words_due  [$];
  typed_word_t typed_words [$];

  int ticks_taken;
  int sent_ticks;
  int mismatches;
  int cycle_count;
  int snd_idle_pct;
  int rcv_idle_pct;
  int stall_reqs;
  int stall_seen;
  logic [15:0] held_keys;

  function automatic logic [TIME_WIDTH-1:0] add_clamped(input logic [TIME_WIDTH-1:0] a,
                                                        input logic [TIME_WIDTH-1:0] b);
    logic [TIME_WIDTH:0] sum;
    sum = a + b;
    if (sum > TIME_MAX) return TIME_MAX;
    return sum[TIME_WIDTH-1:0];
  endfunction

  function automatic void reset_keypad_model();
    scan_row_q = '0;
    hold_threshold_q = THR_RESET;
    repeat_interval_q = INTV_RESET;
    for (int k = 0; k < 16; k++) begin
      key_history[k] = 4'hF;
      key_released[k] = 1'b1;
      key_hold_ms[k] = '0;
      key_repeat_at[k] = THR_RESET;
    end
    ticks_taken = 0;
    words_due.delete();
  endfunction

  // fills tick_words with the words one scan tick should produce
  function automatic void predict_scan_tick(input logic [3:0] levels,
                                            input logic [MS_W-1:0] ms);
    logic [3:0]  hist;
    logic [3:0]  key;
    event_e      kind;
    scan_word_t  w;
    tick_words.delete();
    for (int j = 0; j < 4; j++) begin
      key = 4'(scan_row_q * 4 + j);
      hist = {key_history[key][2:0], levels[j]};
      key_history[key] = hist;
      kind = EV_NONE;
      if (hist == 4'hF) begin
        if (!key_released[key]) begin
          kind = EV_RELEASE;
          key_hold_ms[key] = '0;
        end
        key_released[key] = 1'b1;
      end else if (hist == 4'h0) begin
        if (key_released[key]) begin
          kind = EV_PRESS;
          key_hold_ms[key] = '0;
        end else begin
          key_hold_ms[key] = add_clamped(key_hold_ms[key], {6'd0, ms, 2'b00});
        end
        key_released[key] = 1'b0;
      end
      // repeat check runs even on a mixed history
      if (hold_threshold_q != '0) begin
        if (key_hold_ms[key] >= hold_threshold_q) begin
          if (key_hold_ms[key] >= key_repeat_at[key]) begin
            key_repeat_at[key] = add_clamped(key_repeat_at[key], repeat_interval_q);
            if (kind == EV_NONE) kind = EV_REPEAT;
          end
        end else begin
          key_repeat_at[key] = hold_threshold_q;
        end
      end
      if (kind != EV_NONE) begin
        w.kind = kind;
        w.key = key;
        w.code = KEYPAD_CODES[key*8 +: 8];
        tick_words.push_back(w);
      end
    end
    scan_row_q = scan_row_q + 2'd1;
    if (tick_words.size() == 0) begin
      w.kind = EV_NONE;
      w.key = '0;
      w.code = '0;
      tick_words.push_back(w);
    end
    foreach (tick_words[i]) begin
      tick_words[i].drive_row = scan_row_q;
      tick_words[i].last = (i == tick_words.size() - 1);
    end
  endfunction

  function automatic void note_mismatch(input string what, input scan_word_t want,
                                        input scan_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): exp row=%0d ev=%0d key=%0d code=%h last=%0d,",
                " got row=%0d ev=%0d key=%0d code=%h last=%0d"},
               what, want.drive_row, want.kind, want.key, want.code, want.last,
               got.drive_row, got.kind, got.key, got.code, got.last);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    scan_word_t  got;
    scan_word_t  want;
    typed_word_t tw;
    if (!rst_ni) begin
      reset_keypad_model();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_HOLD_THRESHOLD:  hold_threshold_q = cfg_if.data;
          REG_REPEAT_INTERVAL: repeat_interval_q = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        predict_scan_tick(in_if.column_levels, in_if.elapsed_ms);
        if (typed_words.size() != 0 && typed_words[0].tick_no == ticks_taken) begin
          tw = typed_words.pop_front();
          words_due.push_back(tw.word);
        end else begin
          foreach (tick_words[i]) words_due.push_back(tick_words[i]);
        end
        ticks_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        got.drive_row = out_if.drive_row;
        got.kind = event_e'(out_if.event_kind);
        got.key = out_if.key_index;
        got.code = out_if.key_code;
        got.last = out_if.last;
        if (words_due.size() == 0) begin
          want = '0;
          note_mismatch("unexpected word", want, got);
        end else begin
          want = words_due.pop_front();
          if (got.drive_row !== want.drive_row || got.kind !== want.kind ||
              got.key !== want.key || got.code !== want.code || got.last !== want.last)
            note_mismatch("field", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[matrix_keypad_scanner] ERROR");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_seen != stall_reqs) begin
        stall_seen = stall_reqs;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic send_tick(input logic [3:0] levels, input logic [MS_W-1:0] ms);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.column_levels <= levels;
    in_if.elapsed_ms <= ms;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent_ticks++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] threshold,
                            input logic [CFG_W-1:0] interval);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_HOLD_THRESHOLD;
    cfg_if.data <= threshold;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.index <= REG_REPEAT_INTERVAL;
    cfg_if.data <= interval;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic start_phase(input logic [CFG_W-1:0] threshold,
                             input logic [CFG_W-1:0] interval, input int snd, input int rcv);
    drain_results();
    write_regs(threshold, interval);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  // keys follow held_keys; when noisy, keys change state, contacts bounce
  // and some ticks carry junk levels
  task automatic random_ticks(input int count, input int ms_lo, input int ms_hi,
                              input bit noisy);
    logic [3:0] levels;
    logic [1:0] row;
    int         pick;
    for (int k = 0; k < count; k++) begin
      row = 2'(sent_ticks % 4);
      if (noisy && $urandom_range(9) == 0) begin
        pick = $urandom_range(15);
        held_keys[pick] = ~held_keys[pick];
      end
      levels = ~held_keys[row*4 +: 4];
      if (noisy) begin
        pick = $urandom_range(99);
        if (pick < 10) levels[$urandom_range(3)] = ~levels[$urandom_range(3)];
        else if (pick < 18) levels = 4'($urandom_range(15));
      end
      send_tick(levels, MS_W'($urandom_range(ms_hi, ms_lo)));
    end
  endtask

  initial begin : stimulus
    plan_row_t   plan [25];
    typed_word_t tw;
    plan = '{
      {4'h0, 8'd0,   1'b0, 2'd1},
      {4'hF, 8'd255, 1'b1, 2'd2},
      {4'hF, 8'd255, 1'b1, 2'd3},
      {4'hF, 8'd0,   1'b1, 2'd0},
      {4'h0, 8'd0,   1'b0, 2'd1},
      {4'h5, 8'd7,   1'b1, 2'd2},
      {4'hF, 8'd255, 1'b1, 2'd3},
      {4'hF, 8'd255, 1'b1, 2'd0},
      {4'h0, 8'd0,   1'b0, 2'd1},
      {4'hA, 8'd128, 1'b1, 2'd2},
      {4'hF, 8'd1,   1'b1, 2'd3},
      {4'hF, 8'd254, 1'b1, 2'd0},
      {4'h0, 8'd0,   1'b0, 2'd1},   // row 0 debounced: four presses
      {4'h0, 8'd255, 1'b1, 2'd2},
      {4'hF, 8'd255, 1'b1, 2'd3},
      {4'hF, 8'd255, 1'b1, 2'd0},
      {4'h0, 8'd255, 1'b0, 2'd1},   // hold crosses threshold: repeats
      {4'h0, 8'd0,   1'b1, 2'd2},
      {4'hF, 8'd128, 1'b1, 2'd3},
      {4'hF, 8'd255, 1'b1, 2'd0},
      {4'hA, 8'd255, 1'b0, 2'd1},   // mixed history on two keys
      {4'hF, 8'd3,   1'b1, 2'd2},
      {4'hF, 8'd0,   1'b1, 2'd3},
      {4'h0, 8'd255, 1'b1, 2'd0},
      {4'hF, 8'd200, 1'b0, 2'd1}
    };
    sent_ticks = 0;
    mismatches = 0;
    stall_reqs = 0;
    stall_seen = 0;
    held_keys = '0;
    snd_idle_pct = 29;
    rcv_idle_pct = 49;
    in_if.valid <= 1'b0;
    in_if.column_levels <= '0;
    in_if.elapsed_ms <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_HOLD_THRESHOLD;
    cfg_if.data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].typed) begin
        tw.tick_no = sent_ticks;
        tw.word = '{drive_row: plan[i].next_row, kind: EV_NONE, key: '0, code: '0,
                    last: 1'b1};
        typed_words.push_back(tw);
      end
      send_tick(plan[i].levels, plan[i].ms);
    end

    // fast repeat with a zero step
    start_phase(16'd8, 16'd0, 29, 49);
    random_ticks(30, 0, 12, 1'b1);
    drain_results();
    random_ticks(30, 0, 255, 1'b1);

    // repeat off, widest step
    start_phase(16'd0, 16'hFFFF, 49, 29);
    random_ticks(50, 0, 255, 1'b1);

    start_phase(CFG_W'($urandom_range(2000, 100)), CFG_W'($urandom_range(500, 1)), 0, 0);
    random_ticks(20, 0, 255, 1'b1);
    stall_reqs++;
    random_ticks(40, 0, 255, 1'b1);

    // hold every key through several repeats, then let go
    start_phase(16'd2000, 16'd2500, 0, 0);
    held_keys = '1;
    random_ticks(60, 240, 255, 1'b0);
    held_keys = '0;
    random_ticks(16, 0, 255, 1'b0);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && words_due.size() == 0)
      $display("[matrix_keypad_scanner] OK");
    else
      $display("[matrix_keypad_scanner] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[matrix_keypad_scanner.f]
+incdir+design
design/mkp_pkg.sv
design/mkp_if.sv
design/mkp_lane.sv
design/mkp_merge.sv
design/matrix_keypad_scanner.sv
tb/matrix_keypad_scanner_tb.sv
